>>> src/b26_pkg.sv
// Shared types and constants for the base-26 letter formatter.
// No dependencies; imported by every module under src.
package b26_pkg;

  localparam int RADIX      = 26;
  localparam int MAX_DIGITS = 7;
  localparam int MAX_PAD    = 63;
  localparam int NIBBLES    = 8;
  localparam int FILL_W     = $clog2(MAX_PAD + 1);

  localparam logic [6:0] LETTER_A   = 7'd65;
  localparam logic [6:0] MINUS_SIGN = 7'd45;

  typedef struct packed {
    logic signed [31:0] value;
    logic [5:0]         pad_width;
  } item_t;

  typedef struct packed {
    logic [6:0] character;
    logic       last_char;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

endpackage

>>> src/base26_letter_formatter_core.sv
// Base-26 letter formatter: signed value in, ASCII letters out, one per transaction.
// A transaction is taken only in the idle state; each base-26 digit (up to 7 digits) is
// found by long division, a nibble at a time, through the shared nibble division step, then
// one character per cycle is sent while the output is not stalled.
// Reset clears the sequencer, counters and output valid; the digit store is not cleared.
// Depends on b26_pkg and b26_div_step.
module base26_letter_formatter_core import b26_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  state_t state, state_next;

  logic [31:0]       mag, mag_next;
  logic [4:0]        rem, rem_next;
  logic [2:0]        nib_cnt, nib_cnt_next;
  logic [2:0]        digit_count, digit_count_next;
  logic              negative, negative_next;
  logic [FILL_W-1:0] pad, pad_next;
  logic              sign_pending, sign_pending_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic [2:0]        dig_left, dig_left_next;
  logic              result_valid_next;
  result_t           result_next;
  logic [4:0]        digit_store [MAX_DIGITS];

  logic [3:0]  quo;
  logic [4:0]  step_rem;
  logic [31:0] mag_shift;
  logic        store_we;
  logic        fin;
  logic [2:0]  fin_count;
  logic        load;
  logic [4:0]  rd_digit;

  b26_div_step u_step (
    .rem     (rem),
    .nib     (mag[31:28]),
    .quo     (quo),
    .rem_out (step_rem)
  );

  assign mag_shift = {mag[27:0], quo};
  assign rd_digit  = digit_store[3'(dig_left - 3'd1)];
  assign load      = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      nib_cnt      <= '0;
      digit_count  <= '0;
      sign_pending <= 1'b0;
      fill         <= '0;
      dig_left     <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      nib_cnt      <= nib_cnt_next;
      digit_count  <= digit_count_next;
      sign_pending <= sign_pending_next;
      fill         <= fill_next;
      dig_left     <= dig_left_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    mag      <= mag_next;
    rem      <= rem_next;
    negative <= negative_next;
    pad      <= pad_next;
    result   <= result_next;
    if (store_we) begin
      digit_store[digit_count] <= step_rem;
    end
  end

  always_comb begin
    state_next        = state;
    mag_next          = mag;
    rem_next          = rem;
    nib_cnt_next      = nib_cnt;
    digit_count_next  = digit_count;
    negative_next     = negative;
    pad_next          = pad;
    sign_pending_next = sign_pending;
    fill_next         = fill;
    dig_left_next     = dig_left;
    result_valid_next = result_valid && result_stall;
    result_next       = result;
    store_we          = 1'b0;
    fin               = 1'b0;
    fin_count         = digit_count;
    item_stall        = (state != ST_IDLE);

    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          negative_next    = item.value[31];
          mag_next         = item.value[31] ? (~item.value + 32'd1) : item.value;
          pad_next         = (int'(item.pad_width) > MAX_PAD) ? FILL_W'(MAX_PAD)
                                                              : FILL_W'(item.pad_width);
          rem_next         = '0;
          nib_cnt_next     = '0;
          digit_count_next = '0;
          state_next       = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (nib_cnt == 3'd0 && mag == 32'd0) begin
          fin = 1'b1;
        end else begin
          mag_next     = mag_shift;
          rem_next     = step_rem;
          nib_cnt_next = 3'(nib_cnt + 3'd1);
          if (nib_cnt == 3'(NIBBLES - 1)) begin
            store_we         = 1'b1;
            rem_next         = '0;
            digit_count_next = 3'(digit_count + 3'd1);
            fin_count        = digit_count_next;
            fin = (mag_shift == 32'd0) || (digit_count_next == 3'(MAX_DIGITS));
          end
        end
        if (fin) begin
          sign_pending_next = negative;
          fill_next         = (pad > FILL_W'(fin_count)) ? FILL_W'(pad - FILL_W'(fin_count))
                                                         : '0;
          dig_left_next     = fin_count;
          state_next = (negative || pad > FILL_W'(fin_count) || fin_count != 3'd0)
                       ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (load) begin
          result_valid_next = 1'b1;
          if (sign_pending) begin
            sign_pending_next     = 1'b0;
            result_next.character = MINUS_SIGN;
            result_next.last_char = (fill == '0) && (dig_left == 3'd0);
          end else if (fill != '0) begin
            fill_next             = FILL_W'(fill - 1'b1);
            result_next.character = LETTER_A;
            result_next.last_char = (fill == FILL_W'(1)) && (dig_left == 3'd0);
          end else begin
            dig_left_next         = 3'(dig_left - 3'd1);
            result_next.character = 7'(LETTER_A + {2'b00, rd_digit});
            result_next.last_char = (dig_left == 3'd1);
          end
          if (result_next.last_char) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIVIDE |-> rem < 5'(RADIX))
    else $error("division remainder out of range");

  a_emit_work: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> (sign_pending || fill != '0 || dig_left != 3'd0))
    else $error("emit state with nothing left to send");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.character == MINUS_SIGN |-> !result.last_char)
    else $error("minus sign flagged as final character");

  a_accept_divide: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> state == ST_DIVIDE && digit_count == 3'd0)
    else $error("accepted transaction did not start division");

endmodule

>>> src/b26_div_step.sv
// One radix-16 step of long division by 26: remainder and next nibble in,
// quotient nibble and new remainder out. Depends on b26_pkg.
module b26_div_step import b26_pkg::*; (
  input  logic [4:0] rem,
  input  logic [3:0] nib,
  output logic [3:0] quo,
  output logic [4:0] rem_out
);

  logic [8:0] partial;
  logic [8:0] sub;

  always_comb begin
    partial = {rem, nib};
    quo     = 4'd0;
    sub     = 9'd0;
    for (int k = 1; k < 16; k++) begin
      if (partial >= 9'(RADIX * k)) begin
        quo = 4'(k);
        sub = 9'(RADIX * k);
      end
    end
    rem_out = 5'(partial - sub);
  end

endmodule
